@@ design/box_mean_filter_3x3_macros.svh @@
// assertion macros shared by the box mean filter modules
`ifndef BOX_MEAN_FILTER_3X3_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define BOXM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("box mean filter check failed");
// next-cycle implication, checked at every rising edge outside reset
`define BOXM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("box mean filter check failed");
`else
`define BOXM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BOXM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/boxm_pkg.sv @@
// shared constants, types and reciprocal table of the box mean filter
`timescale 1ns / 1ps
package boxm_pkg;

	// pixel and position widths
	localparam int PIXEL_BITS    = 16;
	localparam int ROW_W         = 10;
	localparam int COL_OUT_W     = 10;
	localparam int MAX_HEIGHT    = 1024;
	localparam int CFG_W         = 11;
	localparam int CFG_IDX_W     = 1;
	localparam int DEF_MAX_WIDTH = 1024;

	// register reset values
	localparam logic [CFG_W-1:0] DEF_IMAGE_WIDTH  = CFG_W'(6);
	localparam logic [CFG_W-1:0] DEF_IMAGE_HEIGHT = CFG_W'(6);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// neighbourhood sum of up to nine pixels and the rounding numerator 2*sum + n
	localparam int SUM_W = PIXEL_BITS + 4;
	localparam int X_W   = SUM_W + 1;
	localparam int CNT_W = 4;

	// reciprocals of 2*n scaled by 2^RECIP_SHIFT, rounded up; exact for all X_W-bit numerators
	localparam int RECIP_SHIFT = X_W + 6;
	localparam logic [RECIP_SHIFT-1:0] RECIP_N1 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2);
	localparam logic [RECIP_SHIFT-1:0] RECIP_N2 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd3) / 64'd4);
	localparam logic [RECIP_SHIFT-1:0] RECIP_N3 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
	localparam logic [RECIP_SHIFT-1:0] RECIP_N4 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd7) / 64'd8);
	localparam logic [RECIP_SHIFT-1:0] RECIP_N6 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12);
	localparam logic [RECIP_SHIFT-1:0] RECIP_N9 =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd17) / 64'd18);

	// one output pixel ready for the divide stage
	typedef struct packed {
		logic [SUM_W-1:0]     sum;
		logic [CNT_W-1:0]     cnt;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
		logic                 eof;
	} cand_t;

	// reciprocal for a neighbourhood of cnt pixels
	function automatic logic [RECIP_SHIFT-1:0] recip_for(input logic [CNT_W-1:0] cnt);
		logic [RECIP_SHIFT-1:0] m;
		case (cnt)
			CNT_W'(1): m = RECIP_N1;
			CNT_W'(2): m = RECIP_N2;
			CNT_W'(3): m = RECIP_N3;
			CNT_W'(4): m = RECIP_N4;
			CNT_W'(6): m = RECIP_N6;
			CNT_W'(9): m = RECIP_N9;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ design/boxm_line_store.sv @@
// two line stores holding the previous two rows, with write-to-read forwarding
`timescale 1ns / 1ps
module boxm_line_store #(
	parameter int DEPTH = boxm_pkg::DEF_MAX_WIDTH,
	parameter int AW    = 10
) (
	input  logic                            clk,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   rd_addr,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   wr_addr,
	input  logic [boxm_pkg::PIXEL_BITS-1:0] wr_old,
	input  logic [boxm_pkg::PIXEL_BITS-1:0] wr_new,
	output logic [boxm_pkg::PIXEL_BITS-1:0] rd_old,
	output logic [boxm_pkg::PIXEL_BITS-1:0] rd_new
);
	import boxm_pkg::*;

	logic [PIXEL_BITS-1:0] older_mem [DEPTH];
	logic [PIXEL_BITS-1:0] newer_mem [DEPTH];
	logic [PIXEL_BITS-1:0] rd_old_q;
	logic [PIXEL_BITS-1:0] rd_new_q;

	// column write from the stage after the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_old;
			newer_mem[wr_addr] <= wr_new;
		end
	end

	// registered read, taking the data being written when both hit one column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_old_q <= wr_old;
				rd_new_q <= wr_new;
			end else begin
				rd_old_q <= older_mem[rd_addr];
				rd_new_q <= newer_mem[rd_addr];
			end
		end
	end

	assign rd_old = rd_old_q;
	assign rd_new = rd_new_q;

endmodule

@@ design/boxm_mean_unit.sv @@
// reciprocal divide stage and output register of the box mean filter
`timescale 1ns / 1ps
`include "box_mean_filter_3x3_macros.svh"
module boxm_mean_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cand_valid,
	input  boxm_pkg::cand_t                  cand,
	output logic                             cand_take,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [boxm_pkg::PIXEL_BITS-1:0]  mean_out,
	output logic [boxm_pkg::ROW_W-1:0]       out_row,
	output logic [boxm_pkg::COL_OUT_W-1:0]   out_col,
	output logic                             last_of_run,
	output logic                             end_of_frame
);
	import boxm_pkg::*;

	logic                          s3_valid;
	cand_t                         cand_s3;
	logic                          s3_go;
	logic [X_W-1:0]                num;
	logic [RECIP_SHIFT-1:0]        recip;
	logic [X_W+RECIP_SHIFT-1:0]    prod;
	logic                          out_valid_q;
	logic [PIXEL_BITS-1:0]         mean_q;
	logic [ROW_W-1:0]              row_q;
	logic [COL_OUT_W-1:0]          col_q;
	logic                          last_q;
	logic                          eof_q;

	// handshake between the sum stage, this stage and the output register
	assign s3_go     = s3_valid && (!out_valid_q || !out_stall);
	assign cand_take = !s3_valid || s3_go;

	// input register of the divide stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (cand_take) begin
			s3_valid <= cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_take && cand_valid) begin
			cand_s3 <= cand;
		end
	end

	// rounded mean: floor((2*sum + n) / (2*n)) by reciprocal multiply
	assign num   = {cand_s3.sum, 1'b0} + X_W'(cand_s3.cnt);
	assign recip = recip_for(cand_s3.cnt);
	assign prod  = num * recip;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			mean_q <= prod[RECIP_SHIFT +: PIXEL_BITS];
			row_q  <= cand_s3.row;
			col_q  <= cand_s3.col;
			last_q <= cand_s3.last;
			eof_q  <= cand_s3.eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign mean_out     = mean_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

	// a result appears only after a candidate sat in the divide stage
	`BOXM_ASSERT_IMP(a_out_from_s3, clk, arst_n, $rose(out_valid_q), $past(s3_valid))
	// a taken candidate always lands in the divide stage
	`BOXM_ASSERT_NXT(a_take_loads, clk, arst_n, cand_valid && cand_take, s3_valid)

endmodule

@@ design/box_mean_filter_3x3.sv @@
// top level of the 3x3 box mean filter
// Streams an image in raster order, one unsigned Q8.8 pixel per transfer, and
// returns the mean of each pixel's 3x3 neighbourhood clipped at the image
// edges, rounded to nearest with ties up, with its row and column. A result
// leaves on the transfer of its last neighbour, so one input gives zero, one,
// two or four results. The input takes one pixel per clock unless stage 1 is
// held; an input that completes two results, or the last pixel of a frame
// (four results), holds the input until the sum stage has handed its results,
// one result per cycle while the output does not stall, to the reciprocal
// multiplier. Two line stores of MAX_WIDTH words each, one read and one write
// a cycle, hold the two previous rows; they need no clearing after reset.
// Write image_width and image_height only while the block is idle; sizes out
// of range are clamped to 1..MAX_WIDTH and 1..1024.
`timescale 1ns / 1ps
`include "box_mean_filter_3x3_macros.svh"
module box_mean_filter_3x3 #(
	parameter int MAX_WIDTH = boxm_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [boxm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [boxm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [boxm_pkg::PIXEL_BITS-1:0] pixel_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [boxm_pkg::PIXEL_BITS-1:0] mean_out,
	output logic [boxm_pkg::ROW_W-1:0]      out_row,
	output logic [boxm_pkg::COL_OUT_W-1:0]  out_col,
	output logic                            last_of_run,
	output logic                            end_of_frame
);
	import boxm_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic [COL_W-1:0]      wm1;
	logic [ROW_W-1:0]      hm1;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic                  accept;

	logic                  s1_valid;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1;
	logic [PIXEL_BITS-1:0] rd_old;
	logic [PIXEL_BITS-1:0] rd_new;
	logic                  rok0;
	logic                  rok1;
	logic                  cok0;
	logic                  cok1;
	logic [3:0]            cand_s1;
	logic                  s1_go;

	logic [PIXEL_BITS-1:0] win_q [3][3];
	logic [3:0]            pend_s2;
	logic [ROW_W-1:0]      row_s2;
	logic [COL_W-1:0]      col_s2;
	logic                  ger1_s2;
	logic                  ger2_s2;
	logic                  gec1_s2;
	logic                  gec2_s2;
	logic [1:0]            pick_k;
	logic [3:0]            pick_oh;
	logic                  pick_last;
	logic [2:0]            inc_r;
	logic [2:0]            inc_c;
	logic [SUM_W-1:0]      term [9];
	logic [1:0]            nr;
	logic [1:0]            nc;
	cand_t                 cand;
	logic                  cand_valid;
	logic                  cand_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DEF_IMAGE_WIDTH;
			height_q <= DEF_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// last column and last row after clamping
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(width_q - CFG_W'(1));
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(height_q - CFG_W'(1));
		end
	end

	// input handshake: stage 1 frees when stage 2 has no pending output or its last one is taken
	assign in_stall = s1_valid && !s1_go;
	assign accept   = in_valid && !in_stall;

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q >= wm1) begin
				col_q <= '0;
				row_q <= (row_q >= hm1) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1: pixel and position while the line stores are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= pixel_in;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	boxm_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (COL_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_old  (rd_new),
		.wr_new  (px_s1),
		.rd_old  (rd_old),
		.rd_new  (rd_new)
	);

	// which of the four outputs around this pixel are now complete
	assign rok0 = (row_s1 != '0) && (row_s1 <= hm1);
	assign rok1 = (row_s1 == hm1);
	assign cok0 = (col_s1 != '0) && (col_s1 <= wm1);
	assign cok1 = (col_s1 == wm1);
	assign cand_s1 = {rok1 && cok1, rok1 && cok0, rok0 && cok1, rok0 && cok0};

	assign s1_go = s1_valid && ((pend_s2 == '0) || (pick_last && cand_take));

	// window shift: newest column enters on the right
	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int a = 0; a < 3; a++) begin
				win_q[a][0] <= win_q[a][1];
				win_q[a][1] <= win_q[a][2];
			end
			win_q[0][2] <= rd_old;
			win_q[1][2] <= rd_new;
			win_q[2][2] <= px_s1;
		end
	end

	// stage 2: pending outputs of the current window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_go) begin
			pend_s2 <= cand_s1;
		end else if (cand_valid && cand_take) begin
			pend_s2 <= pend_s2 & ~pick_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			ger1_s2 <= (row_s1 != '0);
			ger2_s2 <= (row_s1 > ROW_W'(1));
			gec1_s2 <= (col_s1 != '0);
			gec2_s2 <= (col_s1 > COL_W'(1));
		end
	end

	// oldest pending output first
	always_comb begin
		if (pend_s2[0]) begin
			pick_k = 2'd0;
		end else if (pend_s2[1]) begin
			pick_k = 2'd1;
		end else if (pend_s2[2]) begin
			pick_k = 2'd2;
		end else begin
			pick_k = 2'd3;
		end
	end

	assign pick_oh    = 4'b0001 << pick_k;
	assign pick_last  = ((pend_s2 & ~pick_oh) == '0);
	assign cand_valid = (pend_s2 != '0);

	// window rows and columns inside the picked output's neighbourhood
	assign inc_r = {1'b1, ger1_s2, !pick_k[1] && ger2_s2};
	assign inc_c = {1'b1, gec1_s2, !pick_k[0] && gec2_s2};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				term[a*3+b] = (inc_r[a] && inc_c[b]) ? SUM_W'(win_q[a][b]) : '0;
			end
		end
	end

	assign nr = 2'd1 + {1'b0, inc_r[1]} + {1'b0, inc_r[0]};
	assign nc = 2'd1 + {1'b0, inc_c[1]} + {1'b0, inc_c[0]};

	// neighbourhood sum and the picked output's position
	always_comb begin
		cand.sum  = ((term[0] + term[1]) + (term[2] + term[3]))
			+ ((term[4] + term[5]) + (term[6] + term[7])) + term[8];
		cand.cnt  = CNT_W'(nr) * CNT_W'(nc);
		cand.row  = pick_k[1] ? row_s2 : row_s2 - 1'b1;
		cand.col  = COL_OUT_W'(pick_k[0] ? col_s2 : col_s2 - 1'b1);
		cand.last = pick_last;
		cand.eof  = (pick_k == 2'd3);
	end

	boxm_mean_unit u_mean_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cand_valid   (cand_valid),
		.cand         (cand),
		.cand_take    (cand_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_out     (mean_out),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

	// the frame's final pixel is always the last result of its input
	`BOXM_ASSERT_IMP(a_eof_is_last, clk, arst_n, out_valid && end_of_frame, last_of_run)
	// a new window never overwrites more than the one candidate leaving now
	`BOXM_ASSERT_IMP(a_single_pending, clk, arst_n, s1_go, $countones(pend_s2) <= 1)

endmodule
